@@ hdl/mrfb_pkg.sv @@
// Package for the Modbus RTU request frame builder.
// Holds the microcode word, the entry points of the programme and the CRC-16 step.
// No dependencies.
`default_nettype none

package mrfb_pkg;

  localparam int unsigned PcW     = 6;
  localparam int unsigned ProgLen = 34;

  localparam logic [2:0] ModeYearMonth = 3'd0;
  localparam logic [2:0] ModeDayHour   = 3'd1;
  localparam logic [2:0] ModeMinSec    = 3'd2;
  localparam logic [2:0] ModeFullTime  = 3'd3;
  localparam logic [2:0] ModeQuery     = 3'd4;

  // Programme addresses
  localparam logic [PcW-1:0] PcAddr     = 6'd0;
  localparam logic [PcW-1:0] PcCrcTail  = 6'd1;
  localparam logic [PcW-1:0] PcYearMon  = 6'd3;
  localparam logic [PcW-1:0] PcDayHour  = 6'd8;
  localparam logic [PcW-1:0] PcMinSec   = 6'd13;
  localparam logic [PcW-1:0] PcFullTime = 6'd18;
  localparam logic [PcW-1:0] PcQuery    = 6'd29;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_ADDR,
    SRC_YEAR,
    SRC_MONTH,
    SRC_DAY,
    SRC_HOUR,
    SRC_MIN,
    SRC_SEC,
    SRC_CRCL,
    SRC_CRCH
  } src_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_HALT
  } jmp_e;

  typedef struct packed {
    src_e           src;
    logic [7:0]     konst;
    logic           crc_en;
    logic           last;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ucode_t;

  function automatic logic [PcW-1:0] entry_pc(input logic [2:0] mode);
    logic [PcW-1:0] pc;
    pc = PcAddr;
    case (mode)
      ModeYearMonth: pc = PcYearMon;
      ModeDayHour:   pc = PcDayHour;
      ModeMinSec:    pc = PcMinSec;
      ModeFullTime:  pc = PcFullTime;
      ModeQuery:     pc = PcQuery;
      default:       pc = PcAddr;
    endcase
    return pc;
  endfunction

  // Fold one byte into the reflected CRC-16
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/modbus_request_frame_builder_top.sv @@
// Modbus RTU request frame builder, top level: microcode sequencer plus datapath.
// The accepting edge starts the sequencer at the slave address step; its byte is then registered onto the result ports.
// Throughput: one byte per cycle while busy; frames are 8 bytes, or 14 for the full-time write.
// Busy follows the step counter and falls when it halts; the next transaction waits for busy low.
// Reset: asynchronous, active low; clears the sequencer and the strobe. No clearing pass.
// The receiver cannot stall: each byte shows for exactly one cycle.
`default_nettype none

module modbus_request_frame_builder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] mode_i,
  input  wire logic [7:0] slave_address_i,
  input  wire logic [6:0] year_offset_i,
  input  wire logic [3:0] month_i,
  input  wire logic [4:0] day_i,
  input  wire logic [4:0] hour_i,
  input  wire logic [5:0] minute_i,
  input  wire logic [5:0] second_i,
  output logic            out_strobe_o,
  output logic [7:0]      frame_byte_o,
  output logic            last_byte_o
);

  logic                     run_q, run_d;
  logic [mrfb_pkg::PcW-1:0] pc_q, pc_d;
  logic [2:0]               mode_q;
  logic                     accept;
  logic                     launch;
  mrfb_pkg::ucode_t         word;

  // A transaction is taken whenever start meets an idle sequencer; an unused
  // frame kind is taken and dropped without emitting anything.
  assign accept = start & ~run_q;
  assign launch = accept & (mode_i <= mrfb_pkg::ModeQuery);
  assign busy   = run_q;

  mrfb_ucode_rom u_rom (
    .pc_i   (pc_q),
    .word_o (word)
  );

  // Step counter and jump logic
  always_comb begin
    run_d = run_q;
    pc_d  = pc_q;
    if (run_q) begin
      unique case (word.jmp)
        mrfb_pkg::JMP_NEXT:     pc_d = pc_q + 1'b1;
        mrfb_pkg::JMP_GOTO:     pc_d = word.target;
        mrfb_pkg::JMP_DISPATCH: pc_d = mrfb_pkg::entry_pc(mode_q);
        mrfb_pkg::JMP_HALT: begin
          run_d = 1'b0;
          pc_d  = mrfb_pkg::PcAddr;
        end
        default: begin
          run_d = 1'b0;
          pc_d  = mrfb_pkg::PcAddr;
        end
      endcase
    end
    if (launch) begin
      // every programme opens with the slave address byte
      run_d = 1'b1;
      pc_d  = mrfb_pkg::PcAddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      pc_q  <= mrfb_pkg::PcAddr;
    end else begin
      run_q <= run_d;
      pc_q  <= pc_d;
    end
  end

  // Hold the frame kind for the dispatch step
  always_ff @(posedge clk_i) begin
    if (launch) begin
      mode_q <= mode_i;
    end
  end

  mrfb_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (launch),
    .step_i          (run_q),
    .word_i          (word),
    .slave_address_i (slave_address_i),
    .year_offset_i   (year_offset_i),
    .month_i         (month_i),
    .day_i           (day_i),
    .hour_i          (hour_i),
    .minute_i        (minute_i),
    .second_i        (second_i),
    .out_strobe_o    (out_strobe_o),
    .frame_byte_o    (frame_byte_o),
    .last_byte_o     (last_byte_o)
  );

`ifndef ASSERT_OFF
  // A byte only follows a cycle in which the sequencer was running
  a_strobe_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(run_q))
    else $error("strobe without a running step");

  // The step counter never leaves the programme while running
  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (pc_q < mrfb_pkg::ProgLen))
    else $error("step counter outside programme");

  // An unused frame kind is dropped at once
  a_bad_mode_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i > mrfb_pkg::ModeQuery)) |=> !run_q)
    else $error("unused frame kind started a frame");

  // The final byte ends the frame: the sequencer has stopped by then
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> ($past(word.jmp) == mrfb_pkg::JMP_HALT))
    else $error("last byte not at programme end");
`endif

endmodule

`default_nettype wire

@@ hdl/mrfb_ucode_rom.sv @@
// Microcode store of the frame builder: one control word per programme step.
// Depends on mrfb_pkg.
`default_nettype none

module mrfb_ucode_rom (
  input  wire logic [mrfb_pkg::PcW-1:0] pc_i,
  output mrfb_pkg::ucode_t              word_o
);

  function automatic mrfb_pkg::ucode_t uw(input mrfb_pkg::src_e src, input logic [7:0] k,
                                          input mrfb_pkg::jmp_e jmp,
                                          input logic [mrfb_pkg::PcW-1:0] tgt);
    mrfb_pkg::ucode_t w;
    w.src    = src;
    w.konst  = k;
    w.crc_en = (src != mrfb_pkg::SRC_CRCL) && (src != mrfb_pkg::SRC_CRCH);
    w.last   = (src == mrfb_pkg::SRC_CRCH);
    w.jmp    = jmp;
    w.target = tgt;
    return w;
  endfunction

  always_comb begin
    case (pc_i)
      // common head and CRC tail
      6'd0:  word_o = uw(mrfb_pkg::SRC_ADDR,  8'h00, mrfb_pkg::JMP_DISPATCH, '0);
      6'd1:  word_o = uw(mrfb_pkg::SRC_CRCL,  8'h00, mrfb_pkg::JMP_NEXT,     '0);
      6'd2:  word_o = uw(mrfb_pkg::SRC_CRCH,  8'h00, mrfb_pkg::JMP_HALT,     '0);
      // year / month
      6'd3:  word_o = uw(mrfb_pkg::SRC_CONST, 8'h06, mrfb_pkg::JMP_NEXT, '0);
      6'd4:  word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd5:  word_o = uw(mrfb_pkg::SRC_CONST, 8'h05, mrfb_pkg::JMP_NEXT, '0);
      6'd6:  word_o = uw(mrfb_pkg::SRC_YEAR,  8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd7:  word_o = uw(mrfb_pkg::SRC_MONTH, 8'h00, mrfb_pkg::JMP_GOTO, mrfb_pkg::PcCrcTail);
      // day / hour
      6'd8:  word_o = uw(mrfb_pkg::SRC_CONST, 8'h06, mrfb_pkg::JMP_NEXT, '0);
      6'd9:  word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd10: word_o = uw(mrfb_pkg::SRC_CONST, 8'h06, mrfb_pkg::JMP_NEXT, '0);
      6'd11: word_o = uw(mrfb_pkg::SRC_DAY,   8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd12: word_o = uw(mrfb_pkg::SRC_HOUR,  8'h00, mrfb_pkg::JMP_GOTO, mrfb_pkg::PcCrcTail);
      // minute / second
      6'd13: word_o = uw(mrfb_pkg::SRC_CONST, 8'h06, mrfb_pkg::JMP_NEXT, '0);
      6'd14: word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd15: word_o = uw(mrfb_pkg::SRC_CONST, 8'h07, mrfb_pkg::JMP_NEXT, '0);
      6'd16: word_o = uw(mrfb_pkg::SRC_MIN,   8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd17: word_o = uw(mrfb_pkg::SRC_SEC,   8'h00, mrfb_pkg::JMP_GOTO, mrfb_pkg::PcCrcTail);
      // full time, multiple-register write
      6'd18: word_o = uw(mrfb_pkg::SRC_CONST, 8'h10, mrfb_pkg::JMP_NEXT, '0);
      6'd19: word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd20: word_o = uw(mrfb_pkg::SRC_CONST, 8'h05, mrfb_pkg::JMP_NEXT, '0);
      6'd21: word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd22: word_o = uw(mrfb_pkg::SRC_CONST, 8'h03, mrfb_pkg::JMP_NEXT, '0);
      6'd23: word_o = uw(mrfb_pkg::SRC_YEAR,  8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd24: word_o = uw(mrfb_pkg::SRC_MONTH, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd25: word_o = uw(mrfb_pkg::SRC_DAY,   8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd26: word_o = uw(mrfb_pkg::SRC_HOUR,  8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd27: word_o = uw(mrfb_pkg::SRC_MIN,   8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd28: word_o = uw(mrfb_pkg::SRC_SEC,   8'h00, mrfb_pkg::JMP_GOTO, mrfb_pkg::PcCrcTail);
      // input-register query
      6'd29: word_o = uw(mrfb_pkg::SRC_CONST, 8'h04, mrfb_pkg::JMP_NEXT, '0);
      6'd30: word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd31: word_o = uw(mrfb_pkg::SRC_CONST, 8'h21, mrfb_pkg::JMP_NEXT, '0);
      6'd32: word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_NEXT, '0);
      6'd33: word_o = uw(mrfb_pkg::SRC_CONST, 8'h08, mrfb_pkg::JMP_GOTO, mrfb_pkg::PcCrcTail);
      default: word_o = uw(mrfb_pkg::SRC_CONST, 8'h00, mrfb_pkg::JMP_HALT, '0);
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/mrfb_datapath.sv @@
// Datapath of the frame builder: request field registers, byte select, CRC
// accumulator and output registers. Depends on mrfb_pkg.
`default_nettype none

module mrfb_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  mrfb_pkg::ucode_t      word_i,
  input  wire logic [7:0]       slave_address_i,
  input  wire logic [6:0]       year_offset_i,
  input  wire logic [3:0]       month_i,
  input  wire logic [4:0]       day_i,
  input  wire logic [4:0]       hour_i,
  input  wire logic [5:0]       minute_i,
  input  wire logic [5:0]       second_i,
  output logic                  out_strobe_o,
  output logic [7:0]            frame_byte_o,
  output logic                  last_byte_o
);

  logic [7:0]  addr_q;
  logic [6:0]  year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  byte_d, byte_q;
  logic        last_q;
  logic        strobe_q;

  always_comb begin
    unique case (word_i.src)
      mrfb_pkg::SRC_CONST: byte_d = word_i.konst;
      mrfb_pkg::SRC_ADDR:  byte_d = addr_q;
      mrfb_pkg::SRC_YEAR:  byte_d = {1'b0, year_q};
      mrfb_pkg::SRC_MONTH: byte_d = {4'b0, month_q};
      mrfb_pkg::SRC_DAY:   byte_d = {3'b0, day_q};
      mrfb_pkg::SRC_HOUR:  byte_d = {3'b0, hour_q};
      mrfb_pkg::SRC_MIN:   byte_d = {2'b0, minute_q};
      mrfb_pkg::SRC_SEC:   byte_d = {2'b0, second_q};
      mrfb_pkg::SRC_CRCL:  byte_d = crc_q[7:0];
      mrfb_pkg::SRC_CRCH:  byte_d = crc_q[15:8];
      default:             byte_d = word_i.konst;
    endcase
  end

  always_comb begin
    crc_d = crc_q;
    if (load_i) begin
      crc_d = mrfb_pkg::CrcInit;
    end else if (step_i && word_i.crc_en) begin
      crc_d = mrfb_pkg::crc16_byte(crc_q, byte_d);
    end
  end

  // Payload registers, CRC accumulator and output byte registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      addr_q   <= slave_address_i;
      year_q   <= year_offset_i;
      month_q  <= month_i;
      day_q    <= day_i;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      second_q <= second_i;
    end
    crc_q  <= crc_d;
    byte_q <= byte_d;
    last_q <= word_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= step_i;
    end
  end

  assign out_strobe_o = strobe_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = strobe_q & last_q;

endmodule

`default_nettype wire

@@ test/tb_modbus_request_frame_builder_top.sv @@
// Testbench for the Modbus RTU request frame builder top level.
// Drives a directed table and then random requests, and checks every frame byte against a
// built-in frame and CRC-16 predictor. Depends on mrfb_pkg and modbus_request_frame_builder_top.
module tb_modbus_request_frame_builder_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed header bytes of the request frames
  localparam logic [7:0] FnWriteSingle = 8'h06;
  localparam logic [7:0] FnWriteMulti  = 8'h10;
  localparam logic [7:0] FnReadInput   = 8'h04;
  localparam logic [7:0] RegFirst      = 8'h05;
  localparam logic [7:0] RegQuery      = 8'h21;
  localparam logic [7:0] MultiCount    = 8'h03;
  localparam logic [7:0] QueryCount    = 8'h08;
  localparam logic [15:0] CrcSeed      = 16'hFFFF;
  localparam logic [15:0] CrcReflPoly  = 16'hA001;

  localparam int ResetCycles  = 11;
  localparam int RandomItems  = 190;
  localparam int DrainCycles  = 24;
  localparam int CycleLimit   = 200000;
  localparam int DirectedRows = 20;

  // One request transaction; no_frame marks rows typed in as producing nothing
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] addr;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       no_frame;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       tail;
  } frame_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] mode_i = '0;
  logic [7:0] slave_address_i = '0;
  logic [6:0] year_offset_i = '0;
  logic [3:0] month_i = '0;
  logic [4:0] day_i = '0;
  logic [4:0] hour_i = '0;
  logic [5:0] minute_i = '0;
  logic [5:0] second_i = '0;
  logic       out_strobe_o;
  logic [7:0] frame_byte_o;
  logic       last_byte_o;

  frame_byte_t pending_bytes_q[$];
  int          byte_errors = 0;

  // Extremes of every field, every frame kind, and the unused kinds (which send nothing)
  request_t directed_tbl [DirectedRows] = '{
    '{mrfb_pkg::ModeYearMonth, 8'h00, 7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeYearMonth, 8'hFF, 7'd99,  4'd12, 5'd0,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeYearMonth, 8'hA5, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0},
    '{mrfb_pkg::ModeYearMonth, 8'h01, 7'd0,   4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeDayHour,   8'h00, 7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeDayHour,   8'hFF, 7'd0,   4'd0,  5'd31, 5'd23, 6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeDayHour,   8'h5A, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0},
    '{mrfb_pkg::ModeMinSec,    8'h00, 7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeMinSec,    8'hFF, 7'd0,   4'd0,  5'd0,  5'd0,  6'd59, 6'd59, 1'b0},
    '{mrfb_pkg::ModeMinSec,    8'h3C, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0},
    '{mrfb_pkg::ModeFullTime,  8'h00, 7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeFullTime,  8'hFF, 7'd99,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0},
    '{mrfb_pkg::ModeFullTime,  8'hC3, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0},
    '{mrfb_pkg::ModeFullTime,  8'h11, 7'd24,  4'd6,  5'd15, 5'd13, 6'd45, 6'd30, 1'b0},
    '{mrfb_pkg::ModeQuery,     8'h00, 7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeQuery,     8'hFF, 7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b0},
    '{mrfb_pkg::ModeQuery,     8'h01, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0},
    '{3'd5,                    8'hFF, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b1},
    '{3'd6,                    8'h00, 7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b1},
    '{3'd7,                    8'h7E, 7'd99,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b1}
  };

  modbus_request_frame_builder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .slave_address_i (slave_address_i),
    .year_offset_i   (year_offset_i),
    .month_i         (month_i),
    .day_i           (day_i),
    .hour_i          (hour_i),
    .minute_i        (minute_i),
    .second_i        (second_i),
    .out_strobe_o    (out_strobe_o),
    .frame_byte_o    (frame_byte_o),
    .last_byte_o     (last_byte_o)
  );

  always #10 clk_i = ~clk_i;

  // Bit-serial form of the reflected CRC-16: feed each data bit, LSB first, into the LFSR
  function automatic logic [15:0] modbus_crc_fold(input logic [15:0] crc,
                                                  input logic [7:0] data);
    logic [15:0] acc;
    logic        feedback;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      feedback = acc[0] ^ data[i];
      acc = acc >> 1;
      if (feedback) begin
        acc = acc ^ CrcReflPoly;
      end
    end
    return acc;
  endfunction

  // Build the frame a request should produce and queue its bytes in transmit order.
  // Unused frame kinds produce nothing.
  function automatic void predict_request_frame(input request_t r);
    logic [7:0]  body [12];
    int          body_len;
    logic [15:0] crc;
    for (int i = 0; i < 12; i++) begin
      body[i] = 8'h00;
    end
    body[0] = r.addr;
    body_len = 6;
    case (r.mode)
      mrfb_pkg::ModeYearMonth, mrfb_pkg::ModeDayHour, mrfb_pkg::ModeMinSec: begin
        body[1] = FnWriteSingle;
        body[3] = RegFirst + {5'd0, r.mode};
        case (r.mode)
          mrfb_pkg::ModeYearMonth: begin
            body[4] = {1'b0, r.year};
            body[5] = {4'd0, r.month};
          end
          mrfb_pkg::ModeDayHour: begin
            body[4] = {3'd0, r.day};
            body[5] = {3'd0, r.hour};
          end
          default: begin
            body[4] = {2'd0, r.minute};
            body[5] = {2'd0, r.second};
          end
        endcase
      end
      mrfb_pkg::ModeFullTime: begin
        body[1]  = FnWriteMulti;
        body[3]  = RegFirst;
        body[5]  = MultiCount;
        body[6]  = {1'b0, r.year};
        body[7]  = {4'd0, r.month};
        body[8]  = {3'd0, r.day};
        body[9]  = {3'd0, r.hour};
        body[10] = {2'd0, r.minute};
        body[11] = {2'd0, r.second};
        body_len = 12;
      end
      mrfb_pkg::ModeQuery: begin
        body[1] = FnReadInput;
        body[3] = RegQuery;
        body[5] = QueryCount;
      end
      default: begin
        return;
      end
    endcase
    crc = CrcSeed;
    for (int i = 0; i < body_len; i++) begin
      crc = modbus_crc_fold(crc, body[i]);
      pending_bytes_q.push_back('{data: body[i], tail: 1'b0});
    end
    // CRC goes out low byte first; the high byte closes the frame
    pending_bytes_q.push_back('{data: crc[7:0], tail: 1'b0});
    pending_bytes_q.push_back('{data: crc[15:8], tail: 1'b1});
  endfunction

  // Mostly valid frame kinds with in-range fields; some unused kinds and full-width noise
  function automatic request_t random_request();
    request_t r;
    r.no_frame = 1'b0;
    r.addr     = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) < 2) begin
      r.mode = 3'($urandom_range(5, 7));
    end else begin
      r.mode = 3'($urandom_range(0, 4));
    end
    if ($urandom_range(0, 4) == 0) begin
      r.year   = 7'($urandom);
      r.month  = 4'($urandom);
      r.day    = 5'($urandom);
      r.hour   = 5'($urandom);
      r.minute = 6'($urandom);
      r.second = 6'($urandom);
    end else begin
      r.year   = 7'($urandom_range(0, 99));
      r.month  = 4'($urandom_range(1, 12));
      r.day    = 5'($urandom_range(1, 31));
      r.hour   = 5'($urandom_range(0, 23));
      r.minute = 6'($urandom_range(0, 59));
      r.second = 6'($urandom_range(0, 59));
    end
    return r;
  endfunction

  // Issue one request transaction. Enter and leave just after a rising edge; start is left
  // high on return so that a back-to-back request keeps it high without a glitch.
  task automatic send_request(input request_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i          <= r.mode;
    slave_address_i <= r.addr;
    year_offset_i   <= r.year;
    month_i         <= r.month;
    day_i           <= r.day;
    hour_i          <= r.hour;
    minute_i        <= r.minute;
    second_i        <= r.second;
    start           <= 1'b1;
    // Hold the request until an edge sees busy low: that edge takes the transaction
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    if (!r.no_frame) begin
      predict_request_frame(r);
    end
  endtask

  // Draw the sender's idle time; keep a stretch with no idling every so often
  function automatic int draw_gap(input int idx);
    if ((idx % 48) < 10) begin
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // Result checker: every strobed byte must match the oldest pending byte
  always @(posedge clk_i) begin
    frame_byte_t exp_byte;
    if (rst_ni && out_strobe_o === 1'b1) begin
      if (pending_bytes_q.size() == 0) begin
        $error("unexpected frame byte %02h (last %b)", frame_byte_o, last_byte_o);
        byte_errors++;
      end else begin
        exp_byte = pending_bytes_q.pop_front();
        if (frame_byte_o !== exp_byte.data) begin
          $error("frame_byte: expected %02h, got %02h", exp_byte.data, frame_byte_o);
          byte_errors++;
        end
        if (last_byte_o !== exp_byte.tail) begin
          $error("last_byte: expected %b, got %b", exp_byte.tail, last_byte_o);
          byte_errors++;
        end
      end
    end
  end

  // Watchdog: bounded well above the slowest correct run
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    request_t req;
    int       idx;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < DirectedRows; i++) begin
      send_request(directed_tbl[i], (i < 6) ? 0 : $urandom_range(0, 6));
    end

    // Random requests
    idx = 0;
    while (idx < RandomItems) begin
      req = random_request();
      send_request(req, draw_gap(idx));
      // Drop start and let the pipe run dry once mid-run
      if (idx == 90) begin
        start <= 1'b0;
        while (pending_bytes_q.size() != 0) @(posedge clk_i);
      end
      idx++;
    end
    start <= 1'b0;

    // Drain outstanding bytes, then give stray bytes a chance to show
    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_bytes_q.size() != 0) begin
      $error("%0d frame bytes never arrived", pending_bytes_q.size());
      byte_errors++;
    end
    if (byte_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
